@@ sv/rle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the run-length pixel expander.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int unsigned ColorW   = 24;
  localparam int unsigned LenW     = 7;
  localparam int unsigned ScaleW   = 7;
  localparam int unsigned WidthW   = 11;
  localparam int unsigned PosW     = 10;
  localparam int unsigned OrigW    = 16;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam int unsigned DefMaxRun  = 64;
  localparam int unsigned DefMaxRows = 1024;

  localparam logic [WidthW-1:0] MaxWidth     = 11'd1024;
  localparam logic [ScaleW-1:0] ScaleReset   = 7'd1;
  localparam logic [WidthW-1:0] WidthReset   = 11'd64;

  localparam logic [CfgIdxW-1:0] CfgScale = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth = 2'd1;

  typedef struct packed {
    logic load;   // take a new run
    logic emit;   // produce one pixel into the output register
  } rle_cmd_t;

  typedef struct packed {
    logic len_zero;  // incoming run has no pixels
    logic pix_last;  // pixel about to be emitted is the last of the run
    logic out_free;  // output register can take a pixel this cycle
  } rle_status_t;

endpackage

@@ sv/rle_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_ctrl
// Run sequencer: accepts one run at a time and steps the datapath through
// its pixels as the output register frees up.
// ----------------------------------------------------------------------------
module rle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rle_pkg::rle_status_t status_i,
  output rle_pkg::rle_cmd_t    cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  always_comb begin
    cmd_o.load = accept;
    cmd_o.emit = (state_q == StRun) && status_i.out_free;
    state_d    = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && !status_i.len_zero) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (cmd_o.emit && status_i.pix_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/rle_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_dp
// Datapath: config registers, run registers, source position, origin
// multipliers and the output register.
// ----------------------------------------------------------------------------
module rle_dp #(
  parameter int unsigned MAX_RUN  = rle_pkg::DefMaxRun,
  parameter int unsigned MAX_ROWS = rle_pkg::DefMaxRows
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rle_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rle_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [rle_pkg::ColorW-1:0]       run_color_i,
  input  logic [rle_pkg::LenW-1:0]         run_length_i,
  input  logic                             frame_end_i,
  input  rle_pkg::rle_cmd_t                cmd_i,
  output rle_pkg::rle_status_t             status_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rle_pkg::OrigW-1:0]        block_x_o,
  output logic [rle_pkg::OrigW-1:0]        block_y_o,
  output logic [rle_pkg::ChanW-1:0]        red_o,
  output logic [rle_pkg::ChanW-1:0]        green_o,
  output logic [rle_pkg::ChanW-1:0]        blue_o,
  output logic                             run_last_o,
  output logic                             frame_last_o
);

  localparam int unsigned CntW = $clog2(MAX_RUN + 1);
  localparam int unsigned ProdW = rle_pkg::PosW + rle_pkg::ScaleW;
  localparam logic [rle_pkg::WidthW-1:0] RowLim = rle_pkg::WidthW'(MAX_ROWS);
  localparam logic [rle_pkg::LenW-1:0]   RunLim = rle_pkg::LenW'(MAX_RUN);

  logic [rle_pkg::ScaleW-1:0] scale_q;
  logic [rle_pkg::WidthW-1:0] width_q;
  logic [rle_pkg::ColorW-1:0] color_q;
  logic                       fend_q;
  logic [CntW-1:0]            cnt_q;
  logic [rle_pkg::PosW-1:0]   col_q, col_d;
  logic [rle_pkg::PosW-1:0]   row_q, row_d;
  logic                       out_valid_q;

  logic [rle_pkg::LenW-1:0]   len_sat;
  logic [rle_pkg::WidthW-1:0] width_eff;
  logic [rle_pkg::WidthW-1:0] col_inc, row_inc;
  logic [ProdW-1:0]           prod_x, prod_y;
  logic                       pix_last;

  assign len_sat   = (run_length_i > RunLim) ? RunLim : run_length_i;
  assign pix_last  = (cnt_q == CntW'(1));

  assign status_o.len_zero = (len_sat == '0);
  assign status_o.pix_last = pix_last;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // zero or oversize width behaves as the full 1024 columns
  assign width_eff = (width_q == '0 || width_q > rle_pkg::MaxWidth) ? rle_pkg::MaxWidth
                                                                    : width_q;
  assign col_inc = {1'b0, col_q} + 11'd1;
  assign row_inc = {1'b0, row_q} + 11'd1;

  assign prod_x = ProdW'(col_q) * ProdW'(scale_q);
  assign prod_y = ProdW'(row_q) * ProdW'(scale_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (cmd_i.load && status_o.len_zero && frame_end_i) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.emit && pix_last && fend_q) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.emit) begin
      if (col_inc >= width_eff) begin
        col_d = '0;
        row_d = (row_inc >= RowLim) ? '0 : row_inc[rle_pkg::PosW-1:0];
      end else begin
        col_d = col_inc[rle_pkg::PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= rle_pkg::ScaleReset;
      width_q     <= rle_pkg::WidthReset;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == rle_pkg::CfgScale) begin
        scale_q <= cfg_data_i[rle_pkg::ScaleW-1:0];
      end
      if (cfg_we_i && cfg_idx_i == rle_pkg::CfgWidth) begin
        width_q <= cfg_data_i;
      end
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.load) begin
        cnt_q <= CntW'(len_sat);
      end else if (cmd_i.emit) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      color_q <= run_color_i;
      fend_q  <= frame_end_i;
    end
    if (cmd_i.emit) begin
      block_x_o    <= prod_x[ProdW-1:rle_pkg::OrigW] != '0 ? '1
                                                         : prod_x[rle_pkg::OrigW-1:0];
      block_y_o    <= prod_y[ProdW-1:rle_pkg::OrigW] != '0 ? '1
                                                         : prod_y[rle_pkg::OrigW-1:0];
      red_o        <= color_q[23:16];
      green_o      <= color_q[15:8];
      blue_o       <= color_q[7:0];
      run_last_o   <= pix_last;
      frame_last_o <= pix_last && fend_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/rle_run_expand_upscale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_run_expand_upscale
// Run-length pixel expander: one request per run, one result per pixel
// carrying the upscaled block origin and the split color.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) takes one run: color, length and
//   frame-end flag. output channel (out_valid_o / out_stall_i) gives one
//   result per pixel with block origin = source position times scale.
//   runs longer than MAX_RUN are cut to MAX_RUN pixels; a zero-length run
//   gives no output (a zero-length frame-end run still clears the position).
//   the run is taken in the idle state; from the run state its pixels are
//   loaded into the output register, one pixel per cycle while the receiver
//   does not stall. the next run is taken only once the last pixel has been
//   loaded into the output register; an empty run is taken without leaving
//   the idle state. the pace is set by the one pixel per cycle of the
//   one-entry output register.
//   a stall holds the output register and pauses the run.
//   reset returns scale to 1, width to 64 and the position to column 0, row 0.
//   config writes (cfg_we_i) are expected only while no run is in progress.
// ----------------------------------------------------------------------------
module rle_run_expand_upscale #(
  parameter int unsigned MAX_RUN  = rle_pkg::DefMaxRun,
  parameter int unsigned MAX_ROWS = rle_pkg::DefMaxRows
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rle_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rle_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rle_pkg::ColorW-1:0]   run_color_i,
  input  logic [rle_pkg::LenW-1:0]     run_length_i,
  input  logic                         frame_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rle_pkg::OrigW-1:0]    block_x_o,
  output logic [rle_pkg::OrigW-1:0]    block_y_o,
  output logic [rle_pkg::ChanW-1:0]    red_o,
  output logic [rle_pkg::ChanW-1:0]    green_o,
  output logic [rle_pkg::ChanW-1:0]    blue_o,
  output logic                         run_last_o,
  output logic                         frame_last_o
);

  rle_pkg::rle_cmd_t    cmd;
  rle_pkg::rle_status_t status;

  rle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rle_dp #(
    .MAX_RUN  (MAX_RUN),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .run_color_i  (run_color_i),
    .run_length_i (run_length_i),
    .frame_end_i  (frame_end_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .block_x_o    (block_x_o),
    .block_y_o    (block_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .run_last_o   (run_last_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ test/rle_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pixel_checker
// Watches the run and pixel channels of the run-length expander, keeps its
// own copy of scale, width and source position, queues the pixels each run
// should produce and compares every pixel the block hands out.
// ----------------------------------------------------------------------------
module rle_pixel_checker #(
  parameter int unsigned MAX_RUN  = rle_pkg::DefMaxRun,
  parameter int unsigned MAX_ROWS = rle_pkg::DefMaxRows
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rle_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rle_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [rle_pkg::ColorW-1:0]   run_color_i,
  input  logic [rle_pkg::LenW-1:0]     run_length_i,
  input  logic                         frame_end_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [rle_pkg::OrigW-1:0]    block_x_i,
  input  logic [rle_pkg::OrigW-1:0]    block_y_i,
  input  logic [rle_pkg::ChanW-1:0]    red_i,
  input  logic [rle_pkg::ChanW-1:0]    green_i,
  input  logic [rle_pkg::ChanW-1:0]    blue_i,
  input  logic                         run_last_i,
  input  logic                         frame_last_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  typedef struct packed {
    logic [rle_pkg::OrigW-1:0] block_x;
    logic [rle_pkg::OrigW-1:0] block_y;
    logic [rle_pkg::ChanW-1:0] red;
    logic [rle_pkg::ChanW-1:0] green;
    logic [rle_pkg::ChanW-1:0] blue;
    logic                      run_last;
    logic                      frame_last;
  } pixel_t;

  localparam int unsigned RowLimit = (MAX_ROWS < 1 || MAX_ROWS > 1024) ? 1024 : MAX_ROWS;

  pixel_t                     pixel_q[$];
  logic [rle_pkg::ScaleW-1:0] scale_q;
  logic [rle_pkg::WidthW-1:0] width_q;
  logic [rle_pkg::PosW-1:0]   col_q;
  logic [rle_pkg::PosW-1:0]   row_q;
  int unsigned                mismatches = 0;
  int unsigned                waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  function automatic logic [rle_pkg::OrigW-1:0] scaled_origin(
      input logic [rle_pkg::PosW-1:0] pos, input logic [rle_pkg::ScaleW-1:0] scale);
    int unsigned prod;
    prod = 32'(pos) * 32'(scale);
    return (prod > 32'hFFFF) ? 16'hFFFF : prod[rle_pkg::OrigW-1:0];
  endfunction

  // queue the pixels of one run and move the source position along
  task automatic expand_run(input logic [rle_pkg::ColorW-1:0] color,
                            input logic [rle_pkg::LenW-1:0] len_raw, input logic fend);
    int unsigned n;
    int unsigned wlim;
    pixel_t      px;
    n    = (32'(len_raw) > MAX_RUN) ? MAX_RUN : 32'(len_raw);
    wlim = (width_q == '0 || 32'(width_q) > 1024) ? 1024 : 32'(width_q);
    for (int unsigned k = 0; k < n; k++) begin
      px.block_x    = scaled_origin(col_q, scale_q);
      px.block_y    = scaled_origin(row_q, scale_q);
      px.red        = color[23:16];
      px.green      = color[15:8];
      px.blue       = color[7:0];
      px.run_last   = (k + 1 == n);
      px.frame_last = (k + 1 == n) && fend;
      pixel_q.push_back(px);
      if (32'(col_q) + 1 >= wlim) begin
        col_q = '0;
        row_q = (32'(row_q) + 1 >= RowLimit) ? '0 : row_q + 1'b1;
      end else begin
        col_q = col_q + 1'b1;
      end
    end
    if (fend) begin
      col_q = '0;
      row_q = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      pixel_q.delete();
      scale_q = rle_pkg::ScaleReset;
      width_q = rle_pkg::WidthReset;
      col_q   = '0;
      row_q   = '0;
      waiting = 0;
    end else begin
      // pixels leave only after their run has been taken, so check first
      if (out_valid_i && !out_stall_i) begin
        got = '{block_x_i, block_y_i, red_i, green_i, blue_i, run_last_i, frame_last_i};
        if (pixel_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected pixel x=%0d y=%0d rgb=%02h%02h%02h rl=%0b fl=%0b",
                     $realtime, got.block_x, got.block_y, got.red, got.green, got.blue,
                     got.run_last, got.frame_last);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display({"%0t: pixel mismatch, expected x=%0d y=%0d rgb=%02h%02h%02h rl=%0b ",
                        "fl=%0b, got x=%0d y=%0d rgb=%02h%02h%02h rl=%0b fl=%0b"},
                       $realtime, want.block_x, want.block_y, want.red, want.green,
                       want.blue, want.run_last, want.frame_last, got.block_x, got.block_y,
                       got.red, got.green, got.blue, got.run_last, got.frame_last);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expand_run(run_color_i, run_length_i, frame_end_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == rle_pkg::CfgScale)
          scale_q = cfg_data_i[rle_pkg::ScaleW-1:0];
        else if (cfg_idx_i == rle_pkg::CfgWidth)
          width_q = cfg_data_i[rle_pkg::WidthW-1:0];
      end
      waiting = pixel_q.size();
    end
  end

endmodule

@@ test/tb_rle_run_expand_upscale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rle_run_expand_upscale
// Drives runs and register writes into the run-length expander: a directed
// set of edge cases, then random phases over several scale and width
// settings with random stalls on both sides. A checker beside the block
// compares every pixel; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rle_run_expand_upscale;

  typedef enum logic {MixNormal, MixLongFrame} run_mix_e;

  localparam logic [rle_pkg::CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [rle_pkg::CfgIdxW-1:0] CfgSpareHi = 2'd3;
  localparam int unsigned CycleLimit  = 800000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHold    = 300;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [rle_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [rle_pkg::CfgDataW-1:0]  cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [rle_pkg::ColorW-1:0]    run_color_i;
  logic [rle_pkg::LenW-1:0]      run_length_i;
  logic                          frame_end_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [rle_pkg::OrigW-1:0]     block_x_o;
  logic [rle_pkg::OrigW-1:0]     block_y_o;
  logic [rle_pkg::ChanW-1:0]     red_o;
  logic [rle_pkg::ChanW-1:0]     green_o;
  logic [rle_pkg::ChanW-1:0]     blue_o;
  logic                          run_last_o;
  logic                          frame_last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned sender_calm = 0;
  bit          idling_on = 1'b1;
  bit          hold_request = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rle_run_expand_upscale dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .run_color_i, .run_length_i, .frame_end_i,
    .out_valid_o, .out_stall_i, .block_x_o, .block_y_o, .red_o, .green_o, .blue_o,
    .run_last_o, .frame_last_o
  );

  rle_pixel_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .run_color_i, .run_length_i, .frame_end_i,
    .out_valid_i(out_valid_o), .out_stall_i, .block_x_i(block_x_o), .block_y_i(block_y_o),
    .red_i(red_o), .green_i(green_o), .blue_i(blue_o), .run_last_i(run_last_o),
    .frame_last_i(frame_last_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall bursts, calm stretches and one long hold-off
  initial begin
    int unsigned burst;
    int unsigned calm;
    int unsigned hold_left;
    logic        stall_next;
    burst = 0;
    calm = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        stall_next = 1'b1;
        burst--;
      end else if (calm > 0 || !idling_on) begin
        stall_next = 1'b0;
        if (calm > 0) calm--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1: begin
            stall_next = 1'b1;
            burst = $urandom_range(0, 10);
          end
          2: begin
            stall_next = 1'b0;
            calm = $urandom_range(20, 80);
          end
          default: stall_next = 1'b0;
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_run(input logic [rle_pkg::ColorW-1:0] color,
                          input logic [rle_pkg::LenW-1:0] len, input logic fend);
    if (sender_calm > 0) begin
      sender_calm--;
    end else if (idling_on) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 11)) @(negedge clk_i);
        end
        2: sender_calm = $urandom_range(10, 30);
        default: ;
      endcase
    end
    in_valid_i   <= 1'b1;
    run_color_i  <= color;
    run_length_i <= len;
    frame_end_i  <= fend;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // a trailing empty run may still be in flight
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [rle_pkg::CfgIdxW-1:0] idx,
                           input logic [rle_pkg::CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_run(input run_mix_e mix);
    logic [rle_pkg::ColorW-1:0] color;
    logic [rle_pkg::LenW-1:0]   len;
    logic                       fend;
    int unsigned                pick;
    color = rle_pkg::ColorW'($urandom);
    pick  = $urandom_range(0, 19);
    if (mix == MixLongFrame) begin
      len  = (pick < 17) ? 7'd64 : rle_pkg::LenW'($urandom_range(0, 127));
      fend = ($urandom_range(0, 39) == 0);
    end else begin
      if (pick < 2)
        len = '0;
      else if (pick == 2)
        len = rle_pkg::LenW'($urandom_range(65, 127));
      else if (pick < 11)
        len = rle_pkg::LenW'($urandom_range(1, 8));
      else
        len = rle_pkg::LenW'($urandom_range(1, 64));
      fend = ($urandom_range(0, 7) == 0);
    end
    send_run(color, len, fend);
  endtask

  task automatic run_phase(input logic [rle_pkg::CfgDataW-1:0] scale,
                           input logic [rle_pkg::CfgDataW-1:0] width,
                           input int unsigned count, input run_mix_e mix, input bit long_hold);
    drain_all();
    write_reg(rle_pkg::CfgScale, scale);
    write_reg(rle_pkg::CfgWidth, width);
    if (long_hold) hold_request = 1'b1;
    repeat (count) random_run(mix);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= rle_pkg::CfgScale;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    run_color_i  <= '0;
    run_length_i <= '0;
    frame_end_i  <= 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings: scale 1, width 64
    send_run(24'h000000, 7'd1, 1'b0);
    send_run(24'hFFFFFF, 7'd64, 1'b0);
    send_run(24'h123456, 7'd0, 1'b0);
    send_run(24'h800000, 7'd127, 1'b0);  // overlong run
    send_run(24'h00FF00, 7'd65, 1'b0);
    send_run(24'h0000FF, 7'd0, 1'b1);    // empty frame end clears position
    send_run(24'hA5A5A5, 7'd3, 1'b1);
    send_run(24'h5A5A5A, 7'd1, 1'b1);

    // scale zero with upper data bits set, width zero acts as full width
    drain_all();
    write_reg(rle_pkg::CfgScale, 11'h780);
    write_reg(rle_pkg::CfgWidth, 11'h000);
    send_run(24'h654321, 7'd64, 1'b0);
    send_run(24'h0F0F0F, 7'd10, 1'b1);

    // spare indexes are ignored, all-ones data masks to the register widths
    drain_all();
    write_reg(CfgSpareLo, 11'h7FF);
    write_reg(CfgSpareHi, 11'h000);
    write_reg(rle_pkg::CfgScale, 11'h7FF);
    write_reg(rle_pkg::CfgWidth, 11'h7FF);
    send_run(24'hC3C3C3, 7'd64, 1'b0);
    send_run(24'h3C3C3C, 7'd64, 1'b0);
    send_run(24'hF0F0F0, 7'd5, 1'b1);

    drain_all();
    write_reg(rle_pkg::CfgScale, 11'd64);
    write_reg(rle_pkg::CfgWidth, 11'd1);
    send_run(24'h0A0B0C, 7'd3, 1'b0);
    send_run(24'hFEDCBA, 7'd64, 1'b1);

    run_phase(11'd1, 11'd64, 20, MixNormal, 1'b0);
    run_phase(11'd3, 11'd10, 25, MixNormal, 1'b1);
    run_phase(11'd0, 11'd7, 10, MixNormal, 1'b0);
    // one pixel per row: rows wrap and the y origin saturates
    run_phase(11'd127, 11'd1, 20, MixLongFrame, 1'b0);
    // full-width rows: the x origin saturates
    run_phase(11'd127, 11'd1024, 20, MixLongFrame, 1'b0);
    run_phase(11'd64, 11'd1024, 15, MixNormal, 1'b0);
    run_phase(11'd2, 11'd33, 20, MixNormal, 1'b0);
    drain_all();
    idling_on = 1'b0;
    run_phase(11'd7, 11'd100, 40, MixNormal, 1'b0);

    drain_all();
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rle_pkg.sv
sv/rle_ctrl.sv
sv/rle_dp.sv
sv/rle_run_expand_upscale.sv
test/rle_pixel_checker.sv
test/tb_rle_run_expand_upscale.sv
